/* rtl/pect_pkg.sv */
// Shared constants, types for the polygon edge crossing test core.
package pect_pkg;

	localparam int MAX_VERTS  = 8;
	localparam int COORD_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_VERTS);
	localparam int CNT_W      = $clog2(MAX_VERTS + 1);
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int Q_DEPTH    = 2;
	localparam int QPTR_W     = $clog2(Q_DEPTH);
	localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} point_t;

	// vertex store write
	typedef struct packed {
		logic             en;
		logic             sel_b;
		logic [IDX_W-1:0] addr;
		point_t           pt;
	} vwr_t;

	// one test job
	typedef struct packed {
		logic [CNT_W-1:0] cnt_a;
		logic [CNT_W-1:0] cnt_b;
		logic             overlap;
		logic             overflow;
	} job_t;

endpackage

/* rtl/pect_front.sv */
// Vertex intake: counts, bounding boxes, overflow, job build on last B vertex.
module pect_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic                                 poly_select,
	input  logic signed [pect_pkg::COORD_BITS-1:0] vert_x,
	input  logic signed [pect_pkg::COORD_BITS-1:0] vert_y,
	input  logic                                 last_vertex,
	output pect_pkg::vwr_t                       vwr,
	output logic                                 fire,
	output logic                                 push,
	output pect_pkg::job_t                       job
);
	import pect_pkg::*;

	logic [CNT_W-1:0] count_a_q, count_b_q;
	logic             a_closed_q, ovf_q, fire_q;
	logic signed [COORD_BITS-1:0] axmin_q, axmax_q, aymin_q, aymax_q;
	logic signed [COORD_BITS-1:0] bxmin_q, bxmax_q, bymin_q, bymax_q;
	logic [CNT_W-1:0] cnt;
	logic             room;
	logic             a_ok, b_ok;

	assign cnt  = poly_select ? count_b_q : (a_closed_q ? '0 : count_a_q);
	assign room = (cnt < CNT_W'(MAX_VERTS));

	always_comb begin
		vwr.en    = accept & room;
		vwr.sel_b = poly_select;
		vwr.addr  = cnt[IDX_W-1:0];
		vwr.pt.x  = vert_x;
		vwr.pt.y  = vert_y;
	end

	assign a_ok = (count_a_q != '0) && (axmin_q != axmax_q) && (aymin_q != aymax_q);
	assign b_ok = (count_b_q != '0) && (bxmin_q != bxmax_q) && (bymin_q != bymax_q);

	always_comb begin
		job.cnt_a    = count_a_q;
		job.cnt_b    = count_b_q;
		job.overlap  = a_ok && b_ok && (axmin_q < bxmax_q) && (bxmin_q < axmax_q) &&
			(aymin_q < bymax_q) && (bymin_q < aymax_q);
		job.overflow = ovf_q;
	end

	assign push = fire_q;
	assign fire = fire_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q  <= '0;
			count_b_q  <= '0;
			a_closed_q <= 1'b0;
			ovf_q      <= 1'b0;
			fire_q     <= 1'b0;
			axmin_q <= '0; axmax_q <= '0; aymin_q <= '0; aymax_q <= '0;
			bxmin_q <= '0; bxmax_q <= '0; bymin_q <= '0; bymax_q <= '0;
		end else if (fire_q) begin
			fire_q     <= 1'b0;
			count_a_q  <= '0;
			count_b_q  <= '0;
			a_closed_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (accept) begin
			if (!room)
				ovf_q <= 1'b1;
			if (!poly_select) begin
				a_closed_q <= last_vertex;
				count_a_q  <= room ? cnt + CNT_W'(1) : cnt;
				if (room) begin
					if (cnt == '0) begin
						axmin_q <= vert_x; axmax_q <= vert_x;
						aymin_q <= vert_y; aymax_q <= vert_y;
					end else begin
						if (vert_x < axmin_q) axmin_q <= vert_x;
						if (vert_x > axmax_q) axmax_q <= vert_x;
						if (vert_y < aymin_q) aymin_q <= vert_y;
						if (vert_y > aymax_q) aymax_q <= vert_y;
					end
				end
			end else begin
				fire_q <= last_vertex;
				if (room) begin
					count_b_q <= cnt + CNT_W'(1);
					if (cnt == '0) begin
						bxmin_q <= vert_x; bxmax_q <= vert_x;
						bymin_q <= vert_y; bymax_q <= vert_y;
					end else begin
						if (vert_x < bxmin_q) bxmin_q <= vert_x;
						if (vert_x > bxmax_q) bxmax_q <= vert_x;
						if (vert_y < bymin_q) bymin_q <= vert_y;
						if (vert_y > bymax_q) bymax_q <= vert_y;
					end
				end
			end
		end
	end

endmodule

/* rtl/pect_queue.sv */
// Small job FIFO between intake and the edge test engine.
module pect_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pect_pkg::job_t push_word,
	input  logic           pop,
	output pect_pkg::job_t pop_word,
	output logic           not_empty
);
	import pect_pkg::*;

	job_t              mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign not_empty = (cnt_q != '0);
	assign do_pop    = pop & not_empty;
	assign do_push   = push & (cnt_q != QCNT_W'(Q_DEPTH));
	assign pop_word  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= (wp_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wp_q + QPTR_W'(1);
			if (do_pop)
				rp_q <= (rp_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rp_q + QPTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

/* rtl/pect_back.sv */
// Edge test engine: vertex stores, edge pair sequencer, orientation pipeline, result.
module pect_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pect_pkg::vwr_t vwr,
	input  logic           job_valid,
	input  pect_pkg::job_t job,
	output logic           job_pop,
	output logic           active,
	output logic           done,
	output logic           crossing_found,
	output logic           boxes_overlap,
	output logic           vertex_overflow
);
	import pect_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	function automatic logic signed [DIFF_W-1:0] sx(input logic signed [COORD_BITS-1:0] v);
		sx = {v[COORD_BITS-1], v};
	endfunction

	point_t store_a [MAX_VERTS];
	point_t store_b [MAX_VERTS];

	logic [1:0]       state_q;
	logic [IDX_W-1:0] i_q, j_q, i_nx, j_nx;
	logic [CNT_W-1:0] ca_q, cb_q;
	logic             ovl_q, ovf_q, acc_q;
	logic             last_i, last_j, issue;
	logic             done_q, cf_q, bo_q, vo_q;

	point_t a1_s1, a2_s1, b1_s1, b2_s1;
	logic   v_s1, v_s2, v_s3, v_s4;
	point_t pa [4], pb [4], pc [4];
	logic signed [DIFF_W-1:0] dcy_s2 [4], dbx_s2 [4], dby_s2 [4], dcx_s2 [4];
	logic signed [PROD_W-1:0] pl_s3 [4], pr_s3 [4];
	logic [3:0] t_s4;

	assign last_i = (CNT_W'(i_q) + CNT_W'(1) == ca_q);
	assign last_j = (CNT_W'(j_q) + CNT_W'(1) == cb_q);
	assign i_nx   = last_i ? '0 : i_q + IDX_W'(1);
	assign j_nx   = last_j ? '0 : j_q + IDX_W'(1);
	assign issue  = (state_q == ST_RUN);

	assign job_pop = (state_q == ST_IDLE) & job_valid;
	assign active  = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		if (vwr.en) begin
			if (vwr.sel_b)
				store_b[vwr.addr] <= vwr.pt;
			else
				store_a[vwr.addr] <= vwr.pt;
		end
		a1_s1 <= store_a[i_q];
		a2_s1 <= store_a[i_nx];
		b1_s1 <= store_b[j_q];
		b2_s1 <= store_b[j_nx];
	end

	// lanes: (a1,b1,b2) (a2,b1,b2) (a1,a2,b1) (a1,a2,b2)
	always_comb begin
		pa[0] = a1_s1; pb[0] = b1_s1; pc[0] = b2_s1;
		pa[1] = a2_s1; pb[1] = b1_s1; pc[1] = b2_s1;
		pa[2] = a1_s1; pb[2] = a2_s1; pc[2] = b1_s1;
		pa[3] = a1_s1; pb[3] = a2_s1; pc[3] = b2_s1;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			dcy_s2[k] <= sx(pc[k].y) - sx(pa[k].y);
			dbx_s2[k] <= sx(pb[k].x) - sx(pa[k].x);
			dby_s2[k] <= sx(pb[k].y) - sx(pa[k].y);
			dcx_s2[k] <= sx(pc[k].x) - sx(pa[k].x);
			pl_s3[k]  <= dcy_s2[k] * dbx_s2[k];
			pr_s3[k]  <= dby_s2[k] * dcx_s2[k];
			t_s4[k]   <= (pl_s3[k] > pr_s3[k]);
		end
	end

	assign done            = done_q;
	assign crossing_found  = cf_q;
	assign boxes_overlap   = bo_q;
	assign vertex_overflow = vo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			ca_q    <= '0;
			cb_q    <= '0;
			ovl_q   <= 1'b0;
			ovf_q   <= 1'b0;
			acc_q   <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			done_q  <= 1'b0;
			cf_q    <= 1'b0;
			bo_q    <= 1'b0;
			vo_q    <= 1'b0;
		end else begin
			v_s1   <= issue;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= 1'b0;
			if (v_s4 && ((t_s4[0] ^ t_s4[1]) && (t_s4[2] ^ t_s4[3])))
				acc_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						ca_q  <= job.cnt_a;
						cb_q  <= job.cnt_b;
						ovl_q <= job.overlap;
						ovf_q <= job.overflow;
						acc_q <= 1'b0;
						i_q   <= '0;
						j_q   <= '0;
						if (job.overlap) begin
							state_q <= ST_RUN;
						end else begin
							done_q <= 1'b1;
							cf_q   <= 1'b0;
							bo_q   <= 1'b0;
							vo_q   <= job.overflow;
						end
					end
				end
				ST_RUN: begin
					j_q <= j_nx;
					if (last_j) begin
						i_q <= i_nx;
						if (last_i)
							state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!(v_s1 | v_s2 | v_s3 | v_s4)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						cf_q    <= acc_q;
						bo_q    <= ovl_q;
						vo_q    <= ovf_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/polygon_edge_crossing_test_core.sv */
// Top level of the polygon edge crossing test core.
//
//  channel  | handshake          | word
//  ---------+--------------------+------------------------------------------------
//  vertex   | start & !busy      | poly_select, vert_x, vert_y, last_vertex
//  result   | done (one cycle)   | crossing_found, boxes_overlap, vertex_overflow
//
// A vertex is taken when start is high and busy is low; busy stays low between vertices.
// The last vertex of B raises busy; when the boxes overlap, every edge pair is fed
// (one edge pair per cycle) into a four-stage orientation pipeline, else no pair is
// tested; done comes in the first cycle with busy low again.
// Reset clears counts, boxes and control; vertex stores stay undefined.
// Results cannot be stalled; busy only blocks new vertices.
module polygon_edge_crossing_test_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   poly_select,
	input  logic signed [pect_pkg::COORD_BITS-1:0] vert_x,
	input  logic signed [pect_pkg::COORD_BITS-1:0] vert_y,
	input  logic                                   last_vertex,
	output logic                                   done,
	output logic                                   crossing_found,
	output logic                                   boxes_overlap,
	output logic                                   vertex_overflow
);
	import pect_pkg::*;

	vwr_t vwr;
	job_t push_word, pop_word;
	logic accept, fire, push, pop, not_empty, active;

	assign busy   = fire | not_empty | active;
	assign accept = start & ~busy;

	pect_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.poly_select (poly_select),
		.vert_x      (vert_x),
		.vert_y      (vert_y),
		.last_vertex (last_vertex),
		.vwr         (vwr),
		.fire        (fire),
		.push        (push),
		.job         (push_word)
	);

	pect_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.not_empty (not_empty)
	);

	pect_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.vwr             (vwr),
		.job_valid       (not_empty),
		.job             (pop_word),
		.job_pop         (pop),
		.active          (active),
		.done            (done),
		.crossing_found  (crossing_found),
		.boxes_overlap   (boxes_overlap),
		.vertex_overflow (vertex_overflow)
	);

endmodule

/* rtl/pect_chk.sv */
// Port level checks for the polygon edge crossing test core.
module pect_chk (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   start,
	input logic                                   busy,
	input logic                                   poly_select,
	input logic signed [pect_pkg::COORD_BITS-1:0] vert_x,
	input logic signed [pect_pkg::COORD_BITS-1:0] vert_y,
	input logic                                   last_vertex,
	input logic                                   done,
	input logic                                   crossing_found,
	input logic                                   boxes_overlap,
	input logic                                   vertex_overflow
);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held two cycles");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without preceding busy");

	a_last_b_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && poly_select && last_vertex) |=> busy)
		else $error("last B vertex did not start a test");

	a_cross_needs_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !boxes_overlap) |-> !crossing_found)
		else $error("crossing reported without box overlap");

endmodule

bind polygon_edge_crossing_test_core pect_chk u_pect_chk (.*);

/* tb/sv/pect_crossing_checker.sv */
// Checker for the polygon edge crossing core: tracks vertex words, predicts, compares.
module pect_crossing_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic                                   poly_select,
	input  logic signed [pect_pkg::COORD_BITS-1:0] vert_x,
	input  logic signed [pect_pkg::COORD_BITS-1:0] vert_y,
	input  logic                                   last_vertex,
	input  logic                                   done,
	input  logic                                   crossing_found,
	input  logic                                   boxes_overlap,
	input  logic                                   vertex_overflow,
	output int                                     fail_count,
	output int                                     pending
);
	import pect_pkg::*;

	typedef struct packed {
		logic crossing;
		logic overlap;
		logic overflow;
	} outcome_t;

	typedef struct {
		logic signed [COORD_BITS-1:0] x_lo;
		logic signed [COORD_BITS-1:0] x_hi;
		logic signed [COORD_BITS-1:0] y_lo;
		logic signed [COORD_BITS-1:0] y_hi;
	} bbox_t;

	// index 0 = polygon A, 1 = polygon B
	point_t   verts [2][MAX_VERTS];
	int       nverts [2];
	bbox_t    bbox [2];
	logic     dropped;
	logic     a_closed;
	outcome_t expected_q [$];
	int       mismatches;

	task automatic add_point(input int p, input point_t pt);
		if (nverts[p] >= MAX_VERTS) begin
			dropped = 1'b1;
			return;
		end
		verts[p][nverts[p]] = pt;
		if (nverts[p] == 0) begin
			bbox[p].x_lo = pt.x;
			bbox[p].x_hi = pt.x;
			bbox[p].y_lo = pt.y;
			bbox[p].y_hi = pt.y;
		end else begin
			if (pt.x < bbox[p].x_lo) bbox[p].x_lo = pt.x;
			if (pt.x > bbox[p].x_hi) bbox[p].x_hi = pt.x;
			if (pt.y < bbox[p].y_lo) bbox[p].y_lo = pt.y;
			if (pt.y > bbox[p].y_hi) bbox[p].y_hi = pt.y;
		end
		nverts[p]++;
	endtask

	// strict counter-clockwise turn a -> b -> c, exact products
	function automatic bit turns_left(input point_t a, input point_t b, input point_t c);
		longint lhs, rhs;
		lhs = (longint'(c.y) - longint'(a.y)) * (longint'(b.x) - longint'(a.x));
		rhs = (longint'(b.y) - longint'(a.y)) * (longint'(c.x) - longint'(a.x));
		return lhs > rhs;
	endfunction

	function automatic bit segs_cross(input point_t a1, input point_t a2,
			input point_t b1, input point_t b2);
		return (turns_left(a1, b1, b2) != turns_left(a2, b1, b2)) &&
			(turns_left(a1, a2, b1) != turns_left(a1, a2, b2));
	endfunction

	function automatic bit boxes_meet();
		if (nverts[0] == 0 || nverts[1] == 0)
			return 1'b0;
		for (int p = 0; p < 2; p++)
			if (bbox[p].x_lo == bbox[p].x_hi || bbox[p].y_lo == bbox[p].y_hi)
				return 1'b0;
		return bbox[0].x_lo < bbox[1].x_hi && bbox[1].x_lo < bbox[0].x_hi &&
			bbox[0].y_lo < bbox[1].y_hi && bbox[1].y_lo < bbox[0].y_hi;
	endfunction

	function automatic bit any_crossing();
		point_t a1, a2, b1, b2;
		for (int i = 0; i < nverts[0]; i++) begin
			a1 = verts[0][i];
			a2 = verts[0][(i + 1 < nverts[0]) ? i + 1 : 0];
			for (int j = 0; j < nverts[1]; j++) begin
				b1 = verts[1][j];
				b2 = verts[1][(j + 1 < nverts[1]) ? j + 1 : 0];
				if (segs_cross(a1, a2, b1, b2))
					return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic take_vertex(input logic is_b, input point_t pt, input logic last);
		outcome_t res;
		if (!is_b) begin
			if (a_closed) begin
				nverts[0] = 0;
				a_closed  = 1'b0;
			end
			add_point(0, pt);
			if (last)
				a_closed = 1'b1;
		end else begin
			add_point(1, pt);
			if (last) begin
				res.overlap  = boxes_meet();
				res.crossing = res.overlap && any_crossing();
				res.overflow = dropped;
				expected_q.push_back(res);
				nverts[0] = 0;
				nverts[1] = 0;
				dropped   = 1'b0;
				a_closed  = 1'b0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t got, want;
		point_t   pt;
		if (!arst_n) begin
			for (int p = 0; p < 2; p++) begin
				nverts[p] = 0;
				bbox[p]   = '{default: '0};
			end
			dropped    = 1'b0;
			a_closed   = 1'b0;
			mismatches = 0;
			expected_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (done) begin
				got = {crossing_found, boxes_overlap, vertex_overflow};
				if (expected_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result word %b (crossing overlap overflow)",
							$time, got);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display("%0t: mismatch: expected %b got %b (crossing overlap overflow)",
								$time, want, got);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				pt.x = vert_x;
				pt.y = vert_y;
				take_vertex(poly_select, pt, last_vertex);
			end
			fail_count <= mismatches;
			pending    <= expected_q.size();
		end
	end

endmodule

/* tb/sv/polygon_edge_crossing_test_core_test.sv */
// Testbench top for the polygon edge crossing core: clock, reset, stimulus and verdict.
module polygon_edge_crossing_test_core_test;
	import pect_pkg::*;

	localparam logic POLY_A    = 1'b0;
	localparam logic POLY_B    = 1'b1;
	localparam int   C_MIN     = -(2 ** (COORD_BITS - 1));
	localparam int   C_MAX     = 2 ** (COORD_BITS - 1) - 1;
	localparam int   ITEMS     = 1350;
	localparam int   SETTLE    = 100;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         poly_select;
	logic signed [COORD_BITS-1:0] vert_x;
	logic signed [COORD_BITS-1:0] vert_y;
	logic                         last_vertex;
	logic                         done;
	logic                         crossing_found;
	logic                         boxes_overlap;
	logic                         vertex_overflow;
	int                           fail_count;
	int                           pending;

	int sent;
	bit quiet;

	always #5 clk = ~clk;

	polygon_edge_crossing_test_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.poly_select     (poly_select),
		.vert_x          (vert_x),
		.vert_y          (vert_y),
		.last_vertex     (last_vertex),
		.done            (done),
		.crossing_found  (crossing_found),
		.boxes_overlap   (boxes_overlap),
		.vertex_overflow (vertex_overflow)
	);

	pect_crossing_checker i_checker (.*);

	task automatic send_vertex(input logic sel, input int x, input int y, input logic last);
		int r, gap;
		gap = 0;
		if (!quiet) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				gap = 0;
			else if (r < 95)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		poly_select <= sel;
		vert_x      <= x[COORD_BITS-1:0];
		vert_y      <= y[COORD_BITS-1:0];
		last_vertex <= last;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	// hold the sender until every expected result word has come back
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic signed [COORD_BITS-1:0] coord(input int mode, input int c,
			input int span);
		int v;
		if (mode < 65) begin
			v = c + int'($urandom_range(0, 2 * span)) - span;
			if (v > C_MAX) v = C_MAX;
			if (v < C_MIN) v = C_MIN;
		end else if (mode < 85) begin
			v = int'($urandom_range(0, 2 ** COORD_BITS - 1)) + C_MIN;
		end else begin
			case ($urandom_range(0, 5))
				0: v = C_MIN;
				1: v = C_MAX;
				2: v = 0;
				3: v = -1;
				4: v = 1;
				default: v = int'($urandom_range(0, 2 ** COORD_BITS - 1)) + C_MIN;
			endcase
		end
		return v[COORD_BITS-1:0];
	endfunction

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return $urandom_range(1, 2);
		if (r < 90)
			return $urandom_range(3, MAX_VERTS);
		return $urandom_range(MAX_VERTS + 1, MAX_VERTS + 3);
	endfunction

	function automatic int pick_span();
		case ($urandom_range(0, 2))
			0: return 16;
			1: return 400;
			default: return 3000;
		endcase
	endfunction

	function automatic int pick_center();
		return int'($urandom_range(0, 60000)) - 30000;
	endfunction

	task automatic send_pair();
		int mode, a_span, b_span, ax, ay, bx, by, n_a, n_b;
		mode   = $urandom_range(0, 99);
		a_span = pick_span();
		b_span = pick_span();
		ax     = pick_center();
		ay     = pick_center();
		bx     = ax + int'($urandom_range(0, 2 * a_span)) - a_span;
		by     = ay + int'($urandom_range(0, 2 * a_span)) - a_span;
		n_a    = pick_size();
		n_b    = pick_size();
		for (int i = 0; i < n_a; i++)
			send_vertex(POLY_A, int'(coord(mode, ax, a_span)),
				int'(coord(mode, ay, a_span)), i == n_a - 1);
		for (int i = 0; i < n_b; i++)
			send_vertex(POLY_B, int'(coord(mode, bx, b_span)),
				int'(coord(mode, by, b_span)), i == n_b - 1);
	endtask

	// loose words: B before A closes, A restarts, stray last marks
	task automatic send_noise();
		int n, mode, cx, cy;
		n    = $urandom_range(1, 12);
		mode = $urandom_range(0, 99);
		cx   = pick_center();
		cy   = pick_center();
		for (int i = 0; i < n; i++)
			send_vertex($urandom_range(0, 1) ? POLY_B : POLY_A, int'(coord(mode, cx, 300)),
				int'(coord(mode, cy, 300)), $urandom_range(0, 3) == 0);
	endtask

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int seq;
		arst_n      = 1'b0;
		start       = 1'b0;
		poly_select = POLY_A;
		vert_x      = '0;
		vert_y      = '0;
		last_vertex = 1'b0;
		sent        = 0;
		quiet       = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two crossing triangles
		send_vertex(POLY_A, 0, 0, 1'b0);
		send_vertex(POLY_A, 100, 0, 1'b0);
		send_vertex(POLY_A, 0, 100, 1'b1);
		send_vertex(POLY_B, 50, -20, 1'b0);
		send_vertex(POLY_B, 120, 50, 1'b0);
		send_vertex(POLY_B, 50, 120, 1'b1);
		// coordinates at both ends of the range
		send_vertex(POLY_A, C_MIN, C_MIN, 1'b0);
		send_vertex(POLY_A, C_MAX, 0, 1'b0);
		send_vertex(POLY_A, C_MIN, C_MAX, 1'b1);
		send_vertex(POLY_B, C_MAX, C_MIN, 1'b0);
		send_vertex(POLY_B, C_MIN, 0, 1'b0);
		send_vertex(POLY_B, C_MAX, C_MAX, 1'b1);
		// too many A vertices, last mark on a dropped one; single-vertex B
		for (int i = 0; i <= MAX_VERTS; i++)
			send_vertex(POLY_A, 16 * i, (i % 2) ? 200 : -200, i == MAX_VERTS);
		send_vertex(POLY_B, 10, 10, 1'b1);
		// empty A
		send_vertex(POLY_B, -1, -1, 1'b1);
		// new A after A closed
		send_vertex(POLY_A, 5, 5, 1'b1);
		send_vertex(POLY_A, -5, 7, 1'b1);
		send_vertex(POLY_B, 3, 3, 1'b1);
		drain();

		seq = 0;
		while (sent < ITEMS) begin
			quiet = ($urandom_range(0, 99) < 25);
			if ($urandom_range(0, 99) < 75)
				send_pair();
			else
				send_noise();
			seq++;
			if (seq % 25 == 0)
				drain();
		end

		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/pect_pkg.sv
rtl/pect_front.sv
rtl/pect_queue.sv
rtl/pect_back.sv
rtl/polygon_edge_crossing_test_core.sv
rtl/pect_chk.sv
tb/sv/pect_crossing_checker.sv
tb/sv/polygon_edge_crossing_test_core_test.sv
